### rtl/rsd_pkg.sv
package rsd_pkg;

   localparam int unsigned COORD_W = 16;
   localparam int unsigned COL_W   = 13;
   localparam int unsigned NCOL_W  = 14;
   localparam int unsigned RUN_W   = 7;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_W   = 2;

   localparam logic [COORD_W-1:0] MIN_HEIGHT = 16'd4;

   localparam logic [1:0] STATUS_WRITE    = 2'd0;
   localparam logic [1:0] STATUS_PROGRESS = 2'd1;
   localparam logic [1:0] STATUS_ERROR    = 2'd2;

   localparam logic [CSR_W-1:0] CSR_ORIGIN_X     = 2'd0;
   localparam logic [CSR_W-1:0] CSR_ORIGIN_Y     = 2'd1;
   localparam logic [CSR_W-1:0] CSR_IMAGE_WIDTH  = 2'd2;
   localparam logic [CSR_W-1:0] CSR_IMAGE_HEIGHT = 2'd3;

   typedef struct packed {
      logic                is_begin;
      logic [BYTE_W-1:0]   byte_value;
      logic [RUN_W-1:0]    low;
      logic                literal;
      logic                low_zero;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] image_width;
      logic [COORD_W-1:0] image_height;
   } cfg_type;

endpackage

### rtl/rsd_channels.sv
interface rsd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] byte_value;

   modport source (output valid, op, byte_value, input ready);
   modport sink   (input valid, op, byte_value, output ready);
endinterface

interface rsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [15:0] stripe_x;
   logic signed [15:0] stripe_y;
   logic [6:0]         row_count;
   logic [7:0]         pattern;
   logic               image_done;
   logic               last;

   modport source (output valid, status, stripe_x, stripe_y, row_count, pattern,
                   image_done, last, input ready);
   modport sink   (input valid, status, stripe_x, stripe_y, row_count, pattern,
                   image_done, last, output ready);
endinterface

### rtl/rsd_front.sv
module rsd_front #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   rsd_req_if.sink          req_chan,
   input  logic             pop,
   output logic             head_valid,
   output rsd_pkg::cmd_type head
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   rsd_pkg::cmd_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsd_pkg::cmd_type cmd;
   logic             push;
   logic             take;

   always_comb begin
      cmd.is_begin   = ~req_chan.op;
      cmd.byte_value = req_chan.byte_value;
      cmd.low        = req_chan.byte_value[6:0];
      cmd.literal    = req_chan.byte_value[7];
      cmd.low_zero   = (req_chan.byte_value[6:0] == 7'd0);
   end

   assign req_chan.ready = (count_ff != FULL_CNT);
   assign push           = req_chan.valid & req_chan.ready;
   assign head_valid     = (count_ff != '0);
   assign take           = pop & head_valid;
   assign head           = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### rtl/rsd_back.sv
module rsd_back (
   input  logic             clock,
   input  logic             reset,
   input  rsd_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  rsd_pkg::cmd_type head,
   output logic             pop,
   rsd_rsp_if.source        rsp_chan
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_NORM = 5'b00010,
      ST_LIT  = 5'b00100,
      ST_REP  = 5'b01000,
      ST_SKIP = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_REP  = 2'd1,
      PH_LIT  = 2'd2
   } phase_type;

   state_type                        state_ff, state_in;
   phase_type                        phase_ff, phase_in;
   logic [rsd_pkg::RUN_W-1:0]        run_left_ff, run_left_in;
   logic [rsd_pkg::COL_W-1:0]        col_ff, col_in;
   logic [rsd_pkg::COORD_W-1:0]      row_ff, row_in;
   logic                             error_ff, error_in;
   logic                             finished_ff, finished_in;
   logic [rsd_pkg::RUN_W-1:0]        n_ff, n_in;
   logic [rsd_pkg::BYTE_W-1:0]       pat_ff, pat_in;
   logic                             lit_mode_ff, lit_mode_in;

   logic                             out_valid_ff, out_valid_in;
   logic [1:0]                       out_status_ff;
   logic [rsd_pkg::COORD_W-1:0]      out_x_ff, out_y_ff;
   logic [rsd_pkg::RUN_W-1:0]        out_count_ff;
   logic [rsd_pkg::BYTE_W-1:0]       out_pattern_ff;
   logic                             out_done_ff, out_last_ff;

   logic                             emit;
   logic [1:0]                       e_status;
   logic [rsd_pkg::RUN_W-1:0]        e_count;
   logic                             e_done;
   logic                             e_last;
   logic                             can_emit;

   logic [rsd_pkg::COORD_W-1:0]      height;
   logic [rsd_pkg::NCOL_W-1:0]       ncols;
   logic [rsd_pkg::COORD_W:0]        width_ext;
   logic [rsd_pkg::NCOL_W-1:0]       col_ext;
   logic [rsd_pkg::NCOL_W-1:0]       col_next;
   logic                             col_out;
   logic                             col_at_last;
   logic                             row_over;
   logic [rsd_pkg::COORD_W:0]        sum;
   logic [rsd_pkg::COORD_W:0]        over;
   logic [rsd_pkg::COORD_W-1:0]      avail;
   logic                             fits;
   logic [rsd_pkg::COORD_W:0]        row_inc;
   logic                             lit_wrap;

   assign height      = (cfg.image_height < rsd_pkg::MIN_HEIGHT) ? rsd_pkg::MIN_HEIGHT
                                                                  : cfg.image_height;
   assign width_ext   = {1'b0, cfg.image_width} + 17'd7;
   assign ncols       = width_ext[rsd_pkg::COORD_W:3];
   assign col_ext     = {1'b0, col_ff};
   assign col_next    = col_ext + 1'b1;
   assign col_out     = (col_ext >= ncols);
   assign col_at_last = (col_next >= ncols);
   assign row_over    = (row_ff >= height);
   assign sum         = {1'b0, row_ff} + {10'd0, n_ff};
   assign fits        = (sum < {1'b0, height});
   assign over        = sum - {1'b0, height};
   assign avail       = height - row_ff;
   assign row_inc     = {1'b0, row_ff} + 1'b1;
   assign lit_wrap    = (row_inc >= {1'b0, height});
   assign can_emit    = ~out_valid_ff | rsp_chan.ready;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      run_left_in = run_left_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      error_in    = error_ff;
      finished_in = finished_ff;
      n_in        = n_ff;
      pat_in      = pat_ff;
      lit_mode_in = lit_mode_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      e_status    = rsd_pkg::STATUS_PROGRESS;
      e_count     = '0;
      e_done      = 1'b0;
      e_last      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && can_emit) begin
               pop = 1'b1;
               if (head.is_begin) begin
                  phase_in    = PH_CTRL;
                  run_left_in = '0;
                  col_in      = '0;
                  row_in      = '0;
                  error_in    = 1'b0;
                  finished_in = 1'b0;
               end else if (error_ff) begin
                  emit     = 1'b1;
                  e_status = rsd_pkg::STATUS_ERROR;
               end else if (finished_ff) begin
                  emit = 1'b1;
               end else if (phase_ff == PH_LIT) begin
                  pat_in      = head.byte_value;
                  lit_mode_in = 1'b1;
                  state_in    = ST_NORM;
               end else if (phase_ff == PH_REP) begin
                  pat_in      = head.byte_value;
                  lit_mode_in = 1'b0;
                  n_in        = run_left_ff;
                  phase_in    = PH_CTRL;
                  run_left_in = '0;
                  state_in    = ST_NORM;
               end else if (head.low_zero) begin
                  error_in = 1'b1;
                  phase_in = PH_CTRL;
                  emit     = 1'b1;
                  e_status = rsd_pkg::STATUS_ERROR;
               end else begin
                  run_left_in = head.low;
                  phase_in    = head.literal ? PH_LIT : PH_REP;
                  emit        = 1'b1;
               end
            end
         end

         ST_NORM: begin
            if (col_out) begin
               finished_in = 1'b1;
               row_in      = '0;
            end else if (row_over) begin
               row_in = '0;
               if (col_at_last) begin
                  finished_in = 1'b1;
               end else begin
                  col_in = col_next[rsd_pkg::COL_W-1:0];
               end
            end
            if (lit_mode_ff) begin
               state_in = ST_LIT;
            end else if (pat_ff == '0) begin
               state_in = ST_SKIP;
            end else begin
               state_in = ST_REP;
            end
         end

         ST_LIT: begin
            if (can_emit) begin
               state_in = ST_IDLE;
               emit     = 1'b1;
               if (finished_ff) begin
                  e_done = 1'b1;
               end else begin
                  e_status = rsd_pkg::STATUS_WRITE;
                  e_count  = 7'd1;
                  if (run_left_ff <= 7'd1) begin
                     run_left_in = '0;
                     phase_in    = PH_CTRL;
                  end else begin
                     run_left_in = run_left_ff - 1'b1;
                  end
                  row_in = row_inc[rsd_pkg::COORD_W-1:0];
                  if (lit_wrap) begin
                     row_in = '0;
                     if (col_at_last) begin
                        finished_in = 1'b1;
                     end else begin
                        col_in = col_next[rsd_pkg::COL_W-1:0];
                     end
                  end
                  e_done = lit_wrap & col_at_last;
               end
            end
         end

         ST_REP: begin
            if (can_emit) begin
               emit = 1'b1;
               if (finished_ff) begin
                  e_done   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  e_status = rsd_pkg::STATUS_WRITE;
                  if (fits) begin
                     e_count  = n_ff;
                     row_in   = sum[rsd_pkg::COORD_W-1:0];
                     n_in     = '0;
                     state_in = ST_IDLE;
                  end else begin
                     e_count = avail[rsd_pkg::RUN_W-1:0];
                     row_in  = '0;
                     n_in    = over[rsd_pkg::RUN_W-1:0];
                     if (col_at_last) begin
                        finished_in = 1'b1;
                     end else begin
                        col_in = col_next[rsd_pkg::COL_W-1:0];
                     end
                     e_done = col_at_last;
                     e_last = (over[rsd_pkg::RUN_W-1:0] == '0) | col_at_last;
                     if (e_last) begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end

         ST_SKIP: begin
            if (finished_ff) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  e_done   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!fits) begin
               n_in   = over[rsd_pkg::RUN_W-1:0];
               row_in = '0;
               if (col_at_last) begin
                  finished_in = 1'b1;
               end else begin
                  col_in = col_next[rsd_pkg::COL_W-1:0];
               end
            end else if (can_emit) begin
               row_in   = sum[rsd_pkg::COORD_W-1:0];
               n_in     = '0;
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CTRL;
         run_left_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         error_ff     <= 1'b0;
         finished_ff  <= 1'b0;
         lit_mode_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         run_left_ff  <= run_left_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         error_ff     <= error_in;
         finished_ff  <= finished_in;
         lit_mode_ff  <= lit_mode_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      pat_ff <= pat_in;
      if (emit) begin
         out_status_ff <= e_status;
         out_done_ff   <= e_done;
         out_last_ff   <= e_last;
         if (e_status == rsd_pkg::STATUS_WRITE) begin
            out_x_ff       <= cfg.origin_x + {col_ff, 3'b000};
            out_y_ff       <= cfg.origin_y + row_ff;
            out_count_ff   <= e_count;
            out_pattern_ff <= pat_ff;
         end else begin
            out_x_ff       <= '0;
            out_y_ff       <= '0;
            out_count_ff   <= '0;
            out_pattern_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.stripe_x   = out_x_ff;
   assign rsp_chan.stripe_y   = out_y_ff;
   assign rsp_chan.row_count  = out_count_ff;
   assign rsp_chan.pattern    = out_pattern_ff;
   assign rsp_chan.image_done = out_done_ff;
   assign rsp_chan.last       = out_last_ff;

endmodule

### rtl/rle_stripe_image_decoder.sv
// channel   direction  handshake      payload
// req_chan  in         valid / ready  op, byte_value
// rsp_chan  out        valid / ready  status, stripe_x, stripe_y, row_count, pattern,
//                                     image_done, last
// csr       in         csr_we         csr_index, csr_wdata (no read-back)
//
// A control byte, begin, error or post-image request is handled in the idle state; a data byte
// is accepted, its position checked, then its segment made. A repeat byte spanning columns
// gives one segment per column and a skip steps over each column crossed before one result;
// the sequencer steps one segment or column a cycle, a segment only while the output is free.
// Synchronous reset; no clearing pass. Requests queue in front of the sequencer and one
// result register sits at the output, so either side may stall on its own.
module rle_stripe_image_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   rsd_req_if.sink                         req_chan,
   rsd_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [rsd_pkg::CSR_W-1:0]       csr_index,
   input  logic [rsd_pkg::COORD_W-1:0]     csr_wdata
);

   rsd_pkg::cfg_type cfg_ff;
   logic             head_valid;
   rsd_pkg::cmd_type head;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= 16'd0;
         cfg_ff.origin_y     <= 16'd0;
         cfg_ff.image_width  <= 16'd128;
         cfg_ff.image_height <= 16'd128;
      end else if (csr_we) begin
         unique case (csr_index)
            rsd_pkg::CSR_ORIGIN_X:     cfg_ff.origin_x     <= csr_wdata;
            rsd_pkg::CSR_ORIGIN_Y:     cfg_ff.origin_y     <= csr_wdata;
            rsd_pkg::CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            rsd_pkg::CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rsd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.image_done |-> rsp_chan.last)
      else $error("image completion on a result that is not the last of its request");

   a_write_has_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == rsd_pkg::STATUS_WRITE |-> rsp_chan.row_count != 7'd0)
      else $error("segment with no rows");

   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != rsd_pkg::STATUS_WRITE
      |-> rsp_chan.row_count == 7'd0 && rsp_chan.pattern == 8'd0)
      else $error("payload on a non-write result");

   a_error_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == rsd_pkg::STATUS_ERROR |-> !rsp_chan.image_done)
      else $error("bad-data result flagged as image completion");

endmodule
